/* rtl/tlo_pkg.sv */
// Shared types, constants and helpers for the letter order block.
`timescale 1ns / 1ps
package tlo_pkg;

  localparam int AlphaSize = 26;
  localparam int LetterW   = 5;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               word_end;
    logic               list_end;
  } in_beat_t;

  typedef struct packed {
    logic [LetterW-1:0] order_letter;
    logic               ok;
    logic               last;
  } out_beat_t;

  typedef enum logic [2:0] {
    StBuild,
    StRoot,
    StStep,
    StEmit,
    StErr
  } back_state_e;

  typedef enum logic [1:0] {
    MarkNone,
    MarkOpen,
    MarkDone
  } mark_e;

  // lowest set bit of an alphabet-wide mask
  function automatic logic [LetterW-1:0] first_set(logic [AlphaSize-1:0] v);
    logic [LetterW-1:0] r;
    r = '0;
    for (int i = AlphaSize - 1; i >= 0; i--) begin
      if (v[i]) r = LetterW'(i);
    end
    return r;
  endfunction

endpackage

/* rtl/tlo_front.sv */
// Front end: accepts letter beats, tracks word position, reads the previous word.
`timescale 1ns / 1ps
module tlo_front #(
  parameter int MaxWordLen = 64,
  localparam int PosW   = $clog2(MaxWordLen + 1),
  localparam int AddrW  = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1,
  localparam int EntryW = tlo_pkg::LetterW * 2 + 3 + 2 * PosW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlo_pkg::in_beat_t   in_data_i,
  output logic                push_o,
  output logic [EntryW-1:0]   entry_o,
  input  logic                full_i
);

  typedef struct packed {
    logic [tlo_pkg::LetterW-1:0] letter;
    logic                        word_end;
    logic                        list_end;
    logic                        bad;
    logic [PosW-1:0]             pos;
    logic [PosW-1:0]             len;
    logic [tlo_pkg::LetterW-1:0] prev;
  } entry_t;

  logic [tlo_pkg::LetterW-1:0] word_mem [MaxWordLen];
  logic [tlo_pkg::LetterW-1:0] rd_q;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        s1_valid_q, s1_valid_d;
  logic [tlo_pkg::LetterW-1:0] s1_letter_q;
  logic                        s1_we_q, s1_le_q, s1_bad_q;
  logic [PosW-1:0]             s1_pos_q, s1_len_q;
  logic                        acc, good, ovl, store;
  logic [PosW-1:0]             len;
  entry_t                      entry;

  assign push_o     = s1_valid_q && !full_i;
  assign in_stall_o = s1_valid_q && full_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign good  = in_data_i.letter < tlo_pkg::LetterW'(tlo_pkg::AlphaSize);
  assign ovl   = pos_q >= PosW'(MaxWordLen);
  assign store = good && !ovl;
  assign len   = store ? pos_q + PosW'(1) : pos_q;

  always_comb begin
    pos_d      = pos_q;
    s1_valid_d = s1_valid_q;
    if (push_o) s1_valid_d = 1'b0;
    if (acc) begin
      s1_valid_d = 1'b1;
      pos_d      = (in_data_i.word_end || in_data_i.list_end) ? '0 : len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // read-before-write: rd_q gets the previous word's letter at this position
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q        <= word_mem[pos_q[AddrW-1:0]];
      s1_letter_q <= in_data_i.letter;
      s1_we_q     <= in_data_i.word_end;
      s1_le_q     <= in_data_i.list_end;
      s1_bad_q    <= !store;
      s1_pos_q    <= pos_q;
      s1_len_q    <= len;
      if (store) word_mem[pos_q[AddrW-1:0]] <= in_data_i.letter;
    end
  end

  always_comb begin
    entry.letter   = s1_letter_q;
    entry.word_end = s1_we_q;
    entry.list_end = s1_le_q;
    entry.bad      = s1_bad_q;
    entry.pos      = s1_pos_q;
    entry.len      = s1_len_q;
    entry.prev     = rd_q;
  end

  assign entry_o = entry;

endmodule

/* rtl/tlo_fifo.sv */
// Short queue between the front end and the graph back end.
`timescale 1ns / 1ps
module tlo_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PtrW + 1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* rtl/tlo_back.sv */
// Back end: edge table build, depth-first walk and result output.
`timescale 1ns / 1ps
module tlo_back #(
  parameter int MaxWordLen = 64,
  localparam int PosW   = $clog2(MaxWordLen + 1),
  localparam int EntryW = tlo_pkg::LetterW * 2 + 3 + 2 * PosW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  logic [EntryW-1:0]   entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlo_pkg::out_beat_t  out_data_o
);

  localparam int A  = tlo_pkg::AlphaSize;
  localparam int LW = tlo_pkg::LetterW;

  typedef struct packed {
    logic [LW-1:0]   letter;
    logic            word_end;
    logic            list_end;
    logic            bad;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] len;
    logic [LW-1:0]   prev;
  } entry_t;

  entry_t e;
  assign e = entry_i;

  tlo_pkg::back_state_e state_q, state_d;
  logic [A-1:0]    seen_q, seen_d;
  logic [A-1:0]    edge_q [A];
  tlo_pkg::mark_e  mark_q [A];
  logic [LW-1:0]   stk_q  [A];
  logic [LW-1:0]   cur_q  [A];
  logic [LW-1:0]   post_q [A];
  logic [LW-1:0]   depth_q, depth_d, cnt_q, cnt_d, k_q, k_d;
  logic [PosW-1:0] plen_q, plen_d;
  logic            diff_q, diff_d, fwp_q, fwp_d, inval_q, inval_d;
  logic            diff_n, inval_n;
  logic            out_valid_q, out_valid_d;
  tlo_pkg::out_beat_t out_q, out_d;
  logic            out_free, out_load, clear_all;

  // write strobes
  logic            edge_we;
  logic            mark_we;
  logic [LW-1:0]   mark_idx;
  tlo_pkg::mark_e  mark_val;
  logic            stk_we;
  logic [LW-1:0]   stk_idx, stk_val;
  logic            cur_we_a, cur_we_b;
  logic [LW-1:0]   cur_idx_a, cur_val_a, cur_idx_b;
  logic            post_we;

  // walk datapath
  logic [A-1:0]    roots, ge_mask, nb_mask;
  logic [LW-1:0]   top, node, cpos, nb, root;

  assign top  = depth_q - LW'(1);
  assign node = stk_q[top];
  assign cpos = cur_q[top];

  always_comb begin
    for (int i = 0; i < A; i++) begin
      roots[i]   = seen_q[i] && (mark_q[i] == tlo_pkg::MarkNone);
      ge_mask[i] = LW'(i) >= cpos;
    end
  end

  assign nb_mask  = edge_q[node] & ge_mask;
  assign nb       = tlo_pkg::first_set(nb_mask);
  assign root     = tlo_pkg::first_set(roots);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    diff_d    = diff_q;
    fwp_d     = fwp_q;
    plen_d    = plen_q;
    inval_d   = inval_q;
    depth_d   = depth_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    diff_n    = diff_q;
    inval_n   = inval_q;
    pop_o     = 1'b0;
    edge_we   = 1'b0;
    mark_we   = 1'b0;
    mark_idx  = '0;
    mark_val  = tlo_pkg::MarkNone;
    stk_we    = 1'b0;
    stk_idx   = '0;
    stk_val   = '0;
    cur_we_a  = 1'b0;
    cur_idx_a = '0;
    cur_val_a = '0;
    cur_we_b  = 1'b0;
    cur_idx_b = '0;
    post_we   = 1'b0;
    out_load  = 1'b0;
    out_d     = '0;
    clear_all = 1'b0;
    unique case (state_q)
      tlo_pkg::StBuild: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (e.bad) begin
            inval_n = 1'b1;
          end else begin
            seen_d = seen_q | (A'(1) << e.letter);
            if (!fwp_q && !diff_q && e.pos < plen_q && e.prev != e.letter &&
                e.prev < LW'(A)) begin
              edge_we = 1'b1;
              diff_n  = 1'b1;
            end
          end
          if (e.word_end || e.list_end) begin
            // previous word longer with no differing letter: bad prefix
            if (!fwp_q && !diff_n && plen_q > e.len) inval_n = 1'b1;
            plen_d = e.len;
            diff_n = 1'b0;
            fwp_d  = 1'b0;
          end
          diff_d  = diff_n;
          inval_d = inval_n;
          if (e.list_end) state_d = inval_n ? tlo_pkg::StErr : tlo_pkg::StRoot;
        end
      end
      tlo_pkg::StRoot: begin
        if (|roots) begin
          stk_we    = 1'b1;
          stk_idx   = '0;
          stk_val   = root;
          cur_we_b  = 1'b1;
          cur_idx_b = '0;
          mark_we   = 1'b1;
          mark_idx  = root;
          mark_val  = tlo_pkg::MarkOpen;
          depth_d   = LW'(1);
          state_d   = tlo_pkg::StStep;
        end else if (cnt_q == '0) begin
          state_d = tlo_pkg::StErr;
        end else begin
          k_d     = cnt_q - LW'(1);
          state_d = tlo_pkg::StEmit;
        end
      end
      tlo_pkg::StStep: begin
        if (|nb_mask) begin
          cur_we_a  = 1'b1;
          cur_idx_a = top;
          cur_val_a = nb + LW'(1);
          if (mark_q[nb] == tlo_pkg::MarkOpen) begin
            state_d = tlo_pkg::StErr;
          end else if (mark_q[nb] == tlo_pkg::MarkNone && depth_q < LW'(A)) begin
            mark_we   = 1'b1;
            mark_idx  = nb;
            mark_val  = tlo_pkg::MarkOpen;
            stk_we    = 1'b1;
            stk_idx   = depth_q;
            stk_val   = nb;
            cur_we_b  = 1'b1;
            cur_idx_b = depth_q;
            depth_d   = depth_q + LW'(1);
          end
        end else begin
          mark_we  = 1'b1;
          mark_idx = node;
          mark_val = tlo_pkg::MarkDone;
          if (cnt_q < LW'(A)) begin
            post_we = 1'b1;
            cnt_d   = cnt_q + LW'(1);
          end
          depth_d = depth_q - LW'(1);
          if (depth_q == LW'(1)) state_d = tlo_pkg::StRoot;
        end
      end
      tlo_pkg::StEmit: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.order_letter = post_q[k_q];
          out_d.ok           = 1'b1;
          out_d.last         = k_q == '0;
          if (k_q == '0) begin
            clear_all = 1'b1;
            state_d   = tlo_pkg::StBuild;
          end else begin
            k_d = k_q - LW'(1);
          end
        end
      end
      tlo_pkg::StErr: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          clear_all  = 1'b1;
          state_d    = tlo_pkg::StBuild;
        end
      end
      default: state_d = tlo_pkg::StBuild;
    endcase
    if (clear_all) begin
      seen_d  = '0;
      diff_d  = 1'b0;
      fwp_d   = 1'b1;
      plen_d  = '0;
      inval_d = 1'b0;
      depth_d = '0;
      cnt_d   = '0;
    end
    out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlo_pkg::StBuild;
      seen_q      <= '0;
      diff_q      <= 1'b0;
      fwp_q       <= 1'b1;
      plen_q      <= '0;
      inval_q     <= 1'b0;
      depth_q     <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < A; i++) begin
        edge_q[i] <= '0;
        mark_q[i] <= tlo_pkg::MarkNone;
      end
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      diff_q      <= diff_d;
      fwp_q       <= fwp_d;
      plen_q      <= plen_d;
      inval_q     <= inval_d;
      depth_q     <= depth_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (clear_all) begin
        for (int i = 0; i < A; i++) begin
          edge_q[i] <= '0;
          mark_q[i] <= tlo_pkg::MarkNone;
        end
      end else begin
        if (edge_we) edge_q[e.prev] <= edge_q[e.prev] | (A'(1) << e.letter);
        if (mark_we) mark_q[mark_idx] <= mark_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we)   stk_q[stk_idx]   <= stk_val;
    if (cur_we_a) cur_q[cur_idx_a] <= cur_val_a;
    if (cur_we_b) cur_q[cur_idx_b] <= '0;
    if (post_we)  post_q[cnt_q]    <= node;
    if (out_load) out_q            <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/topological_letter_order_top.sv */
// A letter beat is registered in the front end, queued, then added to the edge table;
// one beat per cycle is taken unless the queue is full. A valid list end starts the walk
// over each present letter, edge and root, then one result beat per cycle unless stalled.
// The front end keeps taking letters of the next list during the walk until the queue fills.
// Reset clears all control state at once; no clearing pass is needed.
`timescale 1ns / 1ps
module topological_letter_order_top #(
  parameter int MaxWordLen = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tlo_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tlo_pkg::out_beat_t out_data_o
);

  localparam int PosW   = $clog2(MaxWordLen + 1);
  localparam int EntryW = tlo_pkg::LetterW * 2 + 3 + 2 * PosW;

  logic              push, pop, full, empty;
  logic [EntryW-1:0] push_data, pop_data;

  tlo_front #(.MaxWordLen(MaxWordLen)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (push_data),
    .full_i     (full)
  );

  tlo_fifo #(.Width(EntryW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  tlo_back #(.MaxWordLen(MaxWordLen)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* test/tb_top.sv */
// Testbench for the letter order block: predicts each list's order and checks every result beat.
`timescale 1ns / 1ps
module tb_top;

  localparam int LetterW   = tlo_pkg::LetterW;
  localparam int AlphaSize = tlo_pkg::AlphaSize;
  localparam int MaxLen    = 64;
  localparam int MaxCycles = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tlo_pkg::in_beat_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tlo_pkg::out_beat_t out_data_o;

  topological_letter_order_top #(.MaxWordLen(MaxLen)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [LetterW-1:0]   prev_word [MaxLen];
  int                   prev_len, pos;
  bit                   diff_seen, first_word, bad_list;
  logic [AlphaSize-1:0] seen_mask;
  logic [AlphaSize-1:0] succ [AlphaSize];

  tlo_pkg::in_beat_t  pending_beats [$];
  tlo_pkg::out_beat_t order_expect [$];
  int        errors = 0;
  int        cycles = 0;
  int        sent_items = 0;
  bit        in_taken = 1'b0;
  bit        hold_send = 1'b0;

  function automatic void clear_list();
    prev_len = 0; pos = 0; diff_seen = 0; first_word = 1; bad_list = 0;
    seen_mask = '0;
    for (int i = 0; i < AlphaSize; i++) succ[i] = '0;
  endfunction

  // depth-first walk, ascending roots and neighbors; returns 1 on a cycle
  function automatic bit walk_order(ref logic [LetterW-1:0] post [$]);
    tlo_pkg::mark_e mark [AlphaSize];
    int    stk [$];
    int    cur [$];
    int    node, c;
    for (int i = 0; i < AlphaSize; i++) mark[i] = tlo_pkg::MarkNone;
    for (int r = 0; r < AlphaSize; r++) begin
      if (!seen_mask[r] || mark[r] != tlo_pkg::MarkNone) continue;
      stk.push_back(r); cur.push_back(0); mark[r] = tlo_pkg::MarkOpen;
      while (stk.size() > 0) begin
        node = stk[$];
        c = cur[$];
        while (c < AlphaSize && !succ[node][c]) c++;
        if (c < AlphaSize) begin
          cur[$] = c + 1;
          if (mark[c] == tlo_pkg::MarkOpen) return 1'b1;
          if (mark[c] == tlo_pkg::MarkNone) begin
            mark[c] = tlo_pkg::MarkOpen;
            stk.push_back(c); cur.push_back(0);
          end
        end else begin
          mark[node] = tlo_pkg::MarkDone;
          post.push_back(LetterW'(node));
          void'(stk.pop_back()); void'(cur.pop_back());
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_order(tlo_pkg::in_beat_t b);
    logic [LetterW-1:0] post [$];
    bit                 cyc;
    tlo_pkg::out_beat_t r;
    int                 l;
    l = b.letter;
    if (l >= AlphaSize || pos >= MaxLen) bad_list = 1;
    else begin
      seen_mask[l] = 1'b1;
      if (!first_word && !diff_seen && pos < prev_len && prev_word[pos] != l) begin
        succ[prev_word[pos]][l] = 1'b1;
        diff_seen = 1;
      end
      prev_word[pos] = LetterW'(l);
      pos++;
    end
    if (b.word_end || b.list_end) begin
      if (!first_word && !diff_seen && prev_len > pos) bad_list = 1;
      prev_len = pos; pos = 0; diff_seen = 0; first_word = 0;
    end
    if (!b.list_end) return;
    cyc = bad_list ? 1'b1 : walk_order(post);
    if (cyc || post.size() == 0) begin
      r = '0; r.last = 1'b1;
      order_expect.push_back(r);
    end else begin
      for (int k = post.size() - 1; k >= 0; k--) begin
        r.order_letter = post[k]; r.ok = 1'b1; r.last = (k == 0);
        order_expect.push_back(r);
      end
    end
    clear_list();
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // driver: presents beats at the falling edge, predicts on acceptance
  int send_gap = 0;
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      sent_items++;
      predict_order(in_data_i);
    end
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold stalled beat
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0 && !hold_send) begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  int stall_gap = 0;
  always @(posedge clk_i) begin
    tlo_pkg::out_beat_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (order_expect.size() == 0) begin
        $error("unexpected result beat %p", out_data_o);
        errors++;
      end else begin
        e = order_expect.pop_front();
        if (out_data_o.order_letter !== e.order_letter) begin
          $error("order_letter exp %0d got %0d", e.order_letter, out_data_o.order_letter);
          errors++;
        end
        if (out_data_o.ok !== e.ok) begin
          $error("ok exp %0d got %0d", e.ok, out_data_o.ok);
          errors++;
        end
        if (out_data_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data_o.last);
          errors++;
        end
      end
    end
  end
  always @(negedge clk_i) begin
    if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_gap <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (cycles > MaxCycles) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_word(input int w [$], input bit is_last);
    tlo_pkg::in_beat_t b;
    for (int i = 0; i < w.size(); i++) begin
      b.letter = LetterW'(w[i]);
      b.word_end = (i == w.size() - 1);
      b.list_end = is_last && (i == w.size() - 1);
      pending_beats.push_back(b);
    end
  endtask

  // random sorted-ish list over a window of the alphabet
  task automatic push_list(input int nwords, input int span, input int maxlen);
    int base, w [$], pw [$], len, k;
    base = $urandom_range(0, AlphaSize - span);
    for (int n = 0; n < nwords; n++) begin
      w = {};
      len = $urandom_range(1, maxlen);
      // mostly share a prefix with the previous word
      k = (pw.size() > 0) ? $urandom_range(0, pw.size()) : 0;
      if (k > len) k = len;
      for (int i = 0; i < k; i++) w.push_back(pw[i]);
      for (int i = k; i < len; i++) w.push_back(base + $urandom_range(0, span - 1));
      push_word(w, n == nwords - 1);
      pw = w;
    end
  endtask

  tlo_pkg::in_beat_t nb;
  int wtmp [$];
  initial begin
    clear_list();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    // full alphabet chain: one single-letter word per letter gives a..z
    for (int i = 0; i < AlphaSize; i++) begin
      wtmp = {i};
      push_word(wtmp, i == AlphaSize - 1);
    end
    push_word('{25, 0, 7}, 0);                 // one word with the extreme letters
    push_word('{25, 0}, 1);                    // bad prefix
    push_word('{1, 2}, 0); push_word('{2, 1}, 0); push_word('{1, 3}, 1);  // cycle
    push_word('{3}, 1);                        // one-word list
    nb.letter = 5'd31; nb.word_end = 0; nb.list_end = 1;
    pending_beats.push_back(nb);               // out-of-alphabet letter, list end w/o word end
    nb.letter = 5'd26; nb.word_end = 1; nb.list_end = 0;
    pending_beats.push_back(nb);
    push_word('{4}, 1);
    while (pending_beats.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_send = 1'b1;
    while (order_expect.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    // overlong word
    wtmp = {};
    for (int i = 0; i < MaxLen + 3; i++) wtmp.push_back(i % AlphaSize);
    push_word(wtmp, 1);
    while (sent_items + pending_beats.size() < 420) begin
      case ($urandom_range(0, 9))
        0: begin
          nb.letter = LetterW'($urandom_range(0, 31));
          nb.word_end = $urandom_range(0, 1);
          nb.list_end = ($urandom_range(0, 3) == 0);
          pending_beats.push_back(nb);
        end
        1: push_list($urandom_range(2, 6), 26, 4);
        default: push_list($urandom_range(2, 8), $urandom_range(2, 6), 4);
      endcase
      while (pending_beats.size() > 16) @(posedge clk_i);
    end
    // close any open list
    push_word('{0}, 1);
    while (pending_beats.size() > 0 || in_valid_i) @(posedge clk_i);
    while (order_expect.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && order_expect.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* topological_letter_order_top.f */
rtl/tlo_pkg.sv
rtl/tlo_front.sv
rtl/tlo_fifo.sv
rtl/tlo_back.sv
rtl/topological_letter_order_top.sv
test/tb_top.sv
